/* src/utd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utd_pkg
// Shared widths, status codes and the result bundle of the UTF-8 to UTF-16
// decoder.
// ----------------------------------------------------------------------------
package utd_pkg;

    localparam int BYTE_W     = 8;
    localparam int UNIT_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int CODE_W     = 32;
    // widest partial value held between bytes (6-byte lead after four
    // continuation bytes: 2 + 4 * 6 bits)
    localparam int ACC_W      = 26;
    localparam int REM_W      = 3;
    localparam int RES_MAX    = 3;
    localparam int CNT_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CONSUME_HEADER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GENERATE_HEADER = 2'd1;

    localparam logic [UNIT_W-1:0] BOM_UNIT    = 16'hFEFF;
    localparam logic [UNIT_W-1:0] BOM_SWAPPED = 16'hFFFE;
    localparam logic [UNIT_W-1:0] HI_SURR     = 16'hD800;
    localparam logic [UNIT_W-1:0] LO_SURR     = 16'hDC00;
    localparam logic [CODE_W-1:0] MAX_CODE    = 32'h0010FFFF;
    localparam logic [CODE_W-1:0] BMP_MAX     = 32'h0000FFFF;
    localparam logic [CODE_W-1:0] SUPP_BASE   = 32'h00010000;

    typedef struct packed {
        logic [RES_MAX-1:0][UNIT_W-1:0]   unit;
        logic [RES_MAX-1:0][STATUS_W-1:0] status;
        logic [CNT_W-1:0]                 count;
    } bundle_t;

endpackage

/* src/utd_text_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utd_text_if
// Byte channel into the decoder.
// ----------------------------------------------------------------------------
interface utd_text_if
    import utd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

/* src/utd_unit_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utd_unit_if
// UTF-16 code unit channel out of the decoder.
// ----------------------------------------------------------------------------
interface utd_unit_if
    import utd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [UNIT_W-1:0]   code_unit;
    logic [STATUS_W-1:0] status;
    logic                last_unit;

    modport source (output valid, output code_unit, output status, output last_unit,
                    input ready);
    modport sink   (input valid, input code_unit, input status, input last_unit,
                    output ready);
endinterface

/* src/utd_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utd_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface utd_cfg_if
    import utd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/utd_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utd_decode
// Sequence state, header registers and the per-byte decode that builds the
// bundle of up to three results for one byte.
// ----------------------------------------------------------------------------
module utd_decode
    import utd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  take,
    input  logic [BYTE_W-1:0]     text_byte,
    input  logic                  end_of_text,
    output bundle_t               bundle
);

    logic             consume_reg;
    logic             generate_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_next;
    logic             first_reg;
    logic             first_next;

    logic [CODE_W-1:0] full;
    logic [CODE_W-1:0] value;
    logic [19:0]       ofs;
    logic              finish;
    logic              err;

    assign full = {acc_reg, text_byte[5:0]};
    assign ofs  = 20'(value - SUPP_BASE);

    always_comb
    begin
        logic [CNT_W-1:0] cnt;
        logic             emit_char;
        cnt        = '0;
        emit_char  = 1'b1;
        bundle     = '0;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        first_next = first_reg;
        finish     = 1'b0;
        err        = 1'b0;
        value      = full;

        if (rem_reg != '0)
        begin
            if (text_byte[7:6] != 2'b10)
            begin
                // broken sequence: drop it and the byte
                acc_next = '0;
                rem_next = '0;
                err      = 1'b1;
            end
            else
            begin
                acc_next = full[ACC_W-1:0];
                rem_next = rem_reg - 3'd1;
                finish   = (rem_reg == 3'd1);
            end
        end
        else if (!text_byte[7])
        begin
            finish = 1'b1;
            value  = {24'd0, text_byte};
        end
        else if (!text_byte[6])
        begin
            err = 1'b1;
        end
        else if (!text_byte[5])
        begin
            acc_next = {21'd0, text_byte[4:0]};
            rem_next = 3'd1;
        end
        else if (!text_byte[4])
        begin
            acc_next = {22'd0, text_byte[3:0]};
            rem_next = 3'd2;
        end
        else if (!text_byte[3])
        begin
            acc_next = {23'd0, text_byte[2:0]};
            rem_next = 3'd3;
        end
        else
        begin
            acc_next = {24'd0, text_byte[1:0]};
            rem_next = text_byte[2] ? 3'd5 : 3'd4;
        end

        if (err)
        begin
            bundle.unit[cnt]   = '0;
            bundle.status[cnt] = ST_INVALID;
            cnt                = cnt + 2'd1;
        end

        if (finish)
        begin
            if (!first_reg)
            begin
                first_next = 1'b1;
                if (value == {16'd0, BOM_UNIT} || value == {16'd0, BOM_SWAPPED})
                begin
                    emit_char = 1'b0;
                    if (!consume_reg)
                    begin
                        bundle.unit[cnt]   = BOM_UNIT;
                        bundle.status[cnt] = ST_OK;
                        cnt                = cnt + 2'd1;
                    end
                end
                else if (generate_reg)
                begin
                    bundle.unit[cnt]   = BOM_UNIT;
                    bundle.status[cnt] = ST_OK;
                    cnt                = cnt + 2'd1;
                end
            end
            if (emit_char)
            begin
                if (value > MAX_CODE)
                begin
                    bundle.unit[cnt]   = '0;
                    bundle.status[cnt] = ST_INVALID;
                    cnt                = cnt + 2'd1;
                end
                else if (value > BMP_MAX)
                begin
                    bundle.unit[cnt]   = HI_SURR + {6'd0, ofs[19:10]};
                    bundle.status[cnt] = ST_OK;
                    cnt                = cnt + 2'd1;
                    bundle.unit[cnt]   = LO_SURR + {6'd0, value[9:0]};
                    bundle.status[cnt] = ST_OK;
                    cnt                = cnt + 2'd1;
                end
                else
                begin
                    bundle.unit[cnt]   = value[UNIT_W-1:0];
                    bundle.status[cnt] = ST_OK;
                    cnt                = cnt + 2'd1;
                end
            end
        end

        if (end_of_text)
        begin
            if (rem_next != '0)
            begin
                bundle.unit[cnt]   = '0;
                bundle.status[cnt] = ST_INCOMPLETE;
                cnt                = cnt + 2'd1;
            end
            acc_next   = '0;
            rem_next   = '0;
            first_next = 1'b0;
        end

        bundle.count = cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            consume_reg  <= 1'b0;
            generate_reg <= 1'b0;
            acc_reg      <= '0;
            rem_reg      <= '0;
            first_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_CONSUME_HEADER)
            begin
                consume_reg <= cfg_data[0];
            end
            if (cfg_we && cfg_index == REG_GENERATE_HEADER)
            begin
                generate_reg <= cfg_data[0];
            end
            if (take)
            begin
                acc_reg   <= acc_next;
                rem_reg   <= rem_next;
                first_reg <= first_next;
            end
        end
    end

endmodule

/* src/utd_serial.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utd_serial
// Result register: holds one byte's bundle and hands out its units one per
// cycle while the output is ready, marking the final one.
// ----------------------------------------------------------------------------
module utd_serial
    import utd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  bundle_t bundle,
    output logic    free,
    utd_unit_if.source units
);

    bundle_t          bun_reg;
    logic             vld_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             fire;
    logic             at_last;

    assign at_last         = (idx_reg == bun_reg.count - 2'd1);
    assign fire            = vld_reg && units.ready;
    assign free            = !vld_reg || (fire && at_last);

    assign units.valid     = vld_reg;
    assign units.code_unit = bun_reg.unit[idx_reg];
    assign units.status    = bun_reg.status[idx_reg];
    assign units.last_unit = at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
        end
        else if (free)
        begin
            vld_reg <= load;
            idx_reg <= '0;
        end
        else if (fire)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // payload: take a new bundle only when the old one is gone
    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            bun_reg <= bundle;
        end
    end

endmodule

/* src/utd_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utd_in_stage
// Input register: captures one byte so the channel can take that byte while
// the result register is still draining; a second byte waits.
// ----------------------------------------------------------------------------
module utd_in_stage
    import utd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    output logic              held,
    output logic [BYTE_W-1:0] held_byte,
    output logic              held_end,
    utd_text_if.sink          text
);

    logic              vld_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              end_reg;

    assign text.ready = !vld_reg || take;
    assign held       = vld_reg;
    assign held_byte  = byte_reg;
    assign held_end   = end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            vld_reg <= text.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.ready && text.valid)
        begin
            byte_reg <= text.text_byte;
            end_reg  <= text.end_of_text;
        end
    end

endmodule

/* src/utf8_to_utf16_decoder_top.sv */
`timescale 1ns / 1ps
// Path: the first code unit of a byte is offered after the byte passes the
//   input register and then the result register, when the result register
//   is free.
// Throughput: one byte per cycle while units are taken; a byte giving n units
//   holds the register until all are taken; output paces BOM and pairs.
// Reset: rst_n clears both header registers, the sequence state and all
//   valid flags at once; no clearing pass.
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_top
// UTF-8 byte stream in, UTF-16 code units with status out.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_top
    import utd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    utd_text_if.sink   text,
    utd_unit_if.source units,
    utd_cfg_if.sink    cfg
);

    logic              held;
    logic [BYTE_W-1:0] held_byte;
    logic              held_end;
    logic              free;
    logic              take;
    bundle_t           bundle;

    assign cfg.ready = 1'b1;
    // advance the held byte only when the result register can take its bundle
    assign take      = held && free;

    utd_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .held      (held),
        .held_byte (held_byte),
        .held_end  (held_end),
        .text      (text)
    );

    utd_decode u_dec (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .take        (take),
        .text_byte   (held_byte),
        .end_of_text (held_end),
        .bundle      (bundle)
    );

    utd_serial u_ser (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (take && bundle.count != '0),
        .bundle (bundle),
        .free   (free),
        .units  (units)
    );

endmodule

/* src/utd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utd_checker
// Port-level checks on the code unit channel, bound to the top level.
// ----------------------------------------------------------------------------
module utd_checker
    import utd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                valid,
    input logic                ready,
    input logic [UNIT_W-1:0]   code_unit,
    input logic [STATUS_W-1:0] status,
    input logic                last_unit
);

    // hold a stalled item
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(code_unit) && $stable(status)
                            && $stable(last_unit))
        else $error("stalled code unit changed");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (status == ST_INVALID || status == ST_INCOMPLETE) |-> code_unit == '0)
        else $error("error result carries a nonzero unit");

    a_inc_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status == ST_INCOMPLETE |-> last_unit)
        else $error("incomplete status not on final unit");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> status == ST_OK || status == ST_INVALID || status == ST_INCOMPLETE)
        else $error("undefined status code");

endmodule

bind utf8_to_utf16_decoder_top utd_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid     (units.valid),
    .ready     (units.ready),
    .code_unit (units.code_unit),
    .status    (units.status),
    .last_unit (units.last_unit)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 to UTF-16 decoder. Directed texts cover
// byte-order-mark handling, surrogate pairs, bad lead and continuation bytes,
// out-of-range values and truncated sequences. A long output hold fills the
// block, and random texts run under every header setting. Every code unit is
// checked against a predictor kept in step with the accepted bytes.
// ----------------------------------------------------------------------------
module tb_top;
    import utd_pkg::*;

    localparam int LIMIT_CYCLES   = 200000;
    localparam int TAIL_CYCLES    = 6;
    localparam int RANDOM_ITEMS   = 250;
    localparam int PRESSURE_CHARS = 10;
    localparam int HOLD_CYCLES    = 300;

    // indexes past the last register; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam logic [BYTE_W-1:0] CONT_MIN  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD5_MIN = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD6_MIN = 8'hFC;

    typedef struct packed {
        logic [UNIT_W-1:0]   unit;
        logic [STATUS_W-1:0] status;
        logic                last;
    } unit_item_t;

    typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic clk;
    logic rst_n;

    utd_text_if text_if ();
    utd_unit_if unit_if ();
    utd_cfg_if  cfg_if ();

    utf8_to_utf16_decoder_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_if),
        .units (unit_if),
        .cfg   (cfg_if)
    );

    // decoder copy used for prediction
    logic              hdr_consume;
    logic              hdr_generate;
    logic [CODE_W-1:0] cp_acc;
    logic [REM_W-1:0]  cont_left;
    logic              first_seen;

    unit_item_t unit_q[$];
    unit_item_t unit_want;

    int errors;
    int bytes_sent;
    int texts_sent;
    int units_seen;
    int invalid_seen;
    int incomplete_seen;
    int burst_left;
    bit gaps_on;
    int hold_request;
    int cycle_cnt;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void put_unit(input logic [UNIT_W-1:0] u,
                                     input logic [STATUS_W-1:0] s);
        unit_item_t item;
        item.unit   = u;
        item.status = s;
        item.last   = 1'b0;
        unit_q.push_back(item);
    endfunction

    function automatic void close_char(input logic [CODE_W-1:0] v);
        logic [CODE_W-1:0] hi;
        logic [UNIT_W-1:0] lo;
        if (!first_seen)
        begin
            first_seen = 1'b1;
            if (v == BOM_UNIT || v == BOM_SWAPPED)
            begin
                if (!hdr_consume)
                    put_unit(BOM_UNIT, ST_OK);
                return;
            end
            if (hdr_generate)
                put_unit(BOM_UNIT, ST_OK);
        end
        if (v > MAX_CODE)
            put_unit('0, ST_INVALID);
        else if (v > BMP_MAX)
        begin
            hi = ((v - SUPP_BASE) >> 10) + HI_SURR;
            lo = {6'd0, v[9:0]} + LO_SURR;
            put_unit(hi[UNIT_W-1:0], ST_OK);
            put_unit(lo, ST_OK);
        end
        else
            put_unit(v[UNIT_W-1:0], ST_OK);
    endfunction

    function automatic void predict_byte(input logic [BYTE_W-1:0] b, input logic eot);
        int         n0;
        unit_item_t tail;
        n0 = unit_q.size();
        if (cont_left != 0)
        begin
            if (b < CONT_MIN || b >= LEAD2_MIN)
            begin
                // drop both the open sequence and this byte
                cont_left = '0;
                cp_acc    = '0;
                put_unit('0, ST_INVALID);
            end
            else
            begin
                cp_acc    = (cp_acc << 6) | {26'd0, b[5:0]};
                cont_left = cont_left - 1'b1;
                if (cont_left == 0)
                    close_char(cp_acc);
            end
        end
        else if (b < CONT_MIN)
            close_char({24'd0, b});
        else if (b < LEAD2_MIN)
            put_unit('0, ST_INVALID);
        else if (b < LEAD3_MIN)
        begin
            cp_acc    = {27'd0, b[4:0]};
            cont_left = 3'd1;
        end
        else if (b < LEAD4_MIN)
        begin
            cp_acc    = {28'd0, b[3:0]};
            cont_left = 3'd2;
        end
        else if (b < LEAD5_MIN)
        begin
            cp_acc    = {29'd0, b[2:0]};
            cont_left = 3'd3;
        end
        else
        begin
            cp_acc    = {30'd0, b[1:0]};
            cont_left = (b < LEAD6_MIN) ? 3'd4 : 3'd5;
        end
        if (eot)
        begin
            if (cont_left != 0)
                put_unit('0, ST_INCOMPLETE);
            cp_acc     = '0;
            cont_left  = '0;
            first_seen = 1'b0;
        end
        if (unit_q.size() > n0)
        begin
            tail = unit_q.pop_back();
            tail.last = 1'b1;
            unit_q.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte and register drivers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot);
        int gap;
        if (gaps_on && burst_left <= 0)
        begin
            gap        = $urandom_range(0, 5);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                text_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        text_if.valid       <= 1'b1;
        text_if.text_byte   <= b;
        text_if.end_of_text <= eot;
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
        predict_byte(b, eot);
        bytes_sent++;
        burst_left--;
        if (eot)
            texts_sent++;
    endtask

    // encode cp as an n-byte sequence (overlong allowed), send the first keep bytes
    task automatic send_char(input logic [CODE_W-1:0] cp, input int n, input int keep,
                             input logic eot);
        logic [BYTE_W-1:0] pfx;
        logic [BYTE_W-1:0] mask;
        logic [CODE_W-1:0] part;
        logic [BYTE_W-1:0] b;
        int                k;
        case (n)
            1: begin pfx = 8'h00;     mask = 8'h7F; end
            2: begin pfx = LEAD2_MIN; mask = 8'h1F; end
            3: begin pfx = LEAD3_MIN; mask = 8'h0F; end
            4: begin pfx = LEAD4_MIN; mask = 8'h07; end
            5: begin pfx = LEAD5_MIN; mask = 8'h03; end
            default: begin pfx = LEAD6_MIN; mask = 8'h03; end
        endcase
        for (k = 0; k < keep; k++)
        begin
            part = cp >> (6 * (n - 1 - k));
            if (k == 0)
                b = pfx | (part[7:0] & mask);
            else
                b = CONT_MIN | (part[7:0] & 8'h3F);
            send_byte(b, eot && (k == keep - 1));
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        if (idx == REG_CONSUME_HEADER)
            hdr_consume = data[0];
        else if (idx == REG_GENERATE_HEADER)
            hdr_generate = data[0];
    endtask

    task automatic cfg_done();
        cfg_if.valid <= 1'b0;
    endtask

    // hold input, wait for every expected unit, then let lead-only bytes settle
    task automatic drain_block();
        text_if.valid <= 1'b0;
        while (unit_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic set_headers(input logic c, input logic g);
        drain_block();
        cfg_write(REG_CONSUME_HEADER, c);
        cfg_write(REG_GENERATE_HEADER, g);
        cfg_done();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_char(32'h0000FEFF, 3, 3, 1'b0);   // BOM passed on as FEFF
        send_byte(8'h00, 1'b0);
        send_char(32'h0001F600, 4, 4, 1'b0);   // surrogate pair
        send_byte(8'h80, 1'b0);                // stray continuation
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);                // breaks the open sequence
        send_char(32'h00110000, 4, 4, 1'b0);   // just past the top code point
        send_byte(8'h7F, 1'b1);
    endtask

    task automatic test_header_modes();
        set_headers(1'b1, 1'b0);
        send_char(32'h0000FFFE, 3, 3, 1'b0);   // swapped BOM, dropped
        send_byte(8'h41, 1'b1);
        set_headers(1'b0, 1'b1);
        send_byte(8'h42, 1'b1);                // header prefixed
        drain_block();
        cfg_write(REG_SPARE_2, 1'b1);
        cfg_write(REG_SPARE_3, 1'b0);
        cfg_write(REG_SPARE_2, 1'b0);
        cfg_write(REG_SPARE_3, 1'b1);
        cfg_write(REG_CONSUME_HEADER, 1'b1);
        cfg_done();
        send_byte(8'hF8, 1'b0);
        send_byte(8'h80, 1'b1);                // five-byte lead cut off at end
        send_byte(8'hFF, 1'b1);                // six-byte lead cut off at end
    endtask

    task automatic test_backpressure();
        int i;
        set_headers(1'b0, 1'b0);
        gaps_on      = 1'b0;
        hold_request = HOLD_CYCLES;
        for (i = 0; i < PRESSURE_CHARS; i++)
            send_char($urandom_range(32'h10000, 32'h10FFFF), 4, 4, i == PRESSURE_CHARS - 1);
        gaps_on = 1'b1;
    endtask

    task automatic send_random_text();
        int          nchars;
        int          c;
        int          kind;
        int          n;
        logic        eot;
        logic [31:0] cp;
        nchars = $urandom_range(1, 8);
        for (c = 0; c < nchars; c++)
        begin
            eot  = (c == nchars - 1);
            kind = $urandom_range(0, 99);
            if (kind < 8 && c == 0)
                send_char($urandom_range(0, 1) ? 32'h0000FEFF : 32'h0000FFFE, 3, 3, eot);
            else if (kind < 60)
            begin
                n = $urandom_range(1, 3);
                case (n)
                    1: cp = $urandom_range(0, 32'h7F);
                    2: cp = $urandom_range(0, 32'h7FF);
                    default: cp = $urandom_range(0, 32'hFFFF);
                endcase
                send_char(cp, n, n, eot);
            end
            else if (kind < 72)
            begin
                if ($urandom_range(0, 7) == 0)
                    cp = $urandom_range(32'h110000, 32'h1FFFFF);
                else
                    cp = $urandom_range(32'h10000, 32'h10FFFF);
                send_char(cp, 4, 4, eot);
            end
            else if (kind < 78)
            begin
                n = $urandom_range(5, 6);
                send_char($urandom(), n, n, eot);
            end
            else if (kind < 86)
            begin
                n = $urandom_range(2, 6);
                send_char($urandom(), n, $urandom_range(1, n - 1), eot);
            end
            else if (kind < 94)
                send_byte(8'($urandom_range(0, 255)), eot);
            else
            begin
                n = $urandom_range(2, 6);
                send_char($urandom(), n, $urandom_range(1, n - 1), 1'b0);
                if ($urandom_range(0, 1))
                    send_byte(8'($urandom_range(0, 8'h7F)), eot);
                else
                    send_byte(8'($urandom_range(LEAD2_MIN, 8'hFF)), eot);
            end
        end
    endtask

    task automatic test_random_texts();
        int start;
        int phase_start;
        int p;
        start = bytes_sent;
        p = 0;
        while (bytes_sent - start < RANDOM_ITEMS)
        begin
            // first four phases walk every header setting
            if (p < 4)
                set_headers(p[1], p[0]);
            else
                set_headers(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 50 && bytes_sent - start < RANDOM_ITEMS)
                send_random_text();
            p++;
        end
    endtask

    // ------------------------------------------------------------------
    // Unit receiver: own stall pattern plus a requested long hold
    // ------------------------------------------------------------------
    initial
    begin
        int       hold_left;
        int       mode_left;
        int       rx_phase;
        rx_mode_t rx_mode;
        hold_left     = 0;
        mode_left     = 0;
        rx_phase      = 0;
        rx_mode       = RX_FREE;
        unit_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rx_phase++;
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                unit_if.ready <= 1'b0;
            end
            else
            begin
                if (mode_left <= 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (rx_mode)
                    RX_FREE:   unit_if.ready <= 1'b1;
                    RX_RANDOM: unit_if.ready <= ($urandom_range(0, 3) != 0);
                    default:   unit_if.ready <= ((rx_phase % 5) > 1);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Unit checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && unit_if.valid && unit_if.ready)
        begin
            units_seen++;
            if (unit_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected unit, expected none actual %h/%0d/%0b",
                         $time, unit_if.code_unit, unit_if.status, unit_if.last_unit);
            end
            else
            begin
                unit_want = unit_q.pop_front();
                if (unit_want.status == ST_INVALID)
                    invalid_seen++;
                if (unit_want.status == ST_INCOMPLETE)
                    incomplete_seen++;
                if (unit_if.code_unit !== unit_want.unit)
                begin
                    errors++;
                    $display("%0t: code_unit expected %h actual %h",
                             $time, unit_want.unit, unit_if.code_unit);
                end
                if (unit_if.status !== unit_want.status)
                begin
                    errors++;
                    $display("%0t: status field expected %0d actual %0d",
                             $time, unit_want.status, unit_if.status);
                end
                if (unit_if.last_unit !== unit_want.last)
                begin
                    errors++;
                    $display("%0t: last_unit expected %0b actual %0b",
                             $time, unit_want.last, unit_if.last_unit);
                end
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("%0t: timeout with %0d units still expected", $time, unit_q.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        text_if.valid       = 1'b0;
        text_if.text_byte   = '0;
        text_if.end_of_text = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
        rst_n               = 1'b0;
        hdr_consume         = 1'b0;
        hdr_generate        = 1'b0;
        cp_acc              = '0;
        cont_left           = '0;
        first_seen          = 1'b0;
        errors              = 0;
        bytes_sent          = 0;
        texts_sent          = 0;
        units_seen          = 0;
        invalid_seen        = 0;
        incomplete_seen     = 0;
        burst_left          = 0;
        gaps_on             = 1'b1;
        hold_request        = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_header_modes();
        test_backpressure();
        test_random_texts();
        drain_block();

        $display("summary: %0d bytes in %0d texts, %0d code units checked",
                 bytes_sent, texts_sent, units_seen);
        $display("summary: %0d invalid, %0d incomplete; all header settings, %s; %0d mismatches",
                 invalid_seen, incomplete_seen, "spare registers, long output hold", errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
